### sv/hpd_pkg.sv
// shared constants, types and register codes of the heartbeat pulse detector
// no dependencies; imported by every other file of the block

package hpd_pkg;

   // field widths
   localparam int SAMPLE_BITS  = 10;
   localparam int ELAPSED_W    = 13;
   localparam int INTERVAL_W   = 12;
   localparam int BPM_W        = 8;
   localparam int PERIOD_W     = 4;
   localparam int REFR_W       = 11;
   localparam int TIMEOUT_W    = 12;

   // interval window
   localparam int WINDOW_DEPTH = 10;

   // limits and fixed values
   localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX  = {ELAPSED_W{1'b1}};
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = {INTERVAL_W{1'b1}};
   localparam logic [BPM_W-1:0]      BPM_MAX      = {BPM_W{1'b1}};
   localparam int                    MINUTE_MS    = 60000;

   // dicrotic guard is three fifths of the last interval
   localparam int GUARD_DIVISOR = 5;

   // reset values
   localparam logic [PERIOD_W-1:0]    PERIOD_RESET    = PERIOD_W'(2);
   localparam logic [SAMPLE_BITS-1:0] THRESH_RESET    = SAMPLE_BITS'(512);
   localparam logic [REFR_W-1:0]      REFR_RESET      = REFR_W'(250);
   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = TIMEOUT_W'(2500);
   localparam logic [INTERVAL_W-1:0]  INTERVAL_RESET  = INTERVAL_W'(600);
   localparam logic [INTERVAL_W-1:0]  GUARD_RESET     =
      INTERVAL_W'((600 / GUARD_DIVISOR) * 3);

   // serial divider and running window sum
   localparam int DIV_W = 16;
   localparam int CNT_W = $clog2(DIV_W);
   localparam int SUM_W = $clog2(WINDOW_DEPTH * 4095 + 1);

   // reciprocal multipliers for the constant divisions, rounded up
   localparam int GUARD_SHIFT = 14;
   localparam int GUARD_RECIP = (2**GUARD_SHIFT + GUARD_DIVISOR - 1) / GUARD_DIVISOR;
   localparam int MEAN_SHIFT  = 19;
   localparam int MEAN_RECIP  = (2**MEAN_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

   // stream widths, padded to whole bytes
   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = BPM_W + 1 + 1 + INTERVAL_W + SAMPLE_BITS;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_THR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT       = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      logic        eval;
      logic        div_start;
      logic        store_guard;
      logic        store_mean;
      logic        store_rate;
      logic        rate_sat;
      logic        load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic beat;
      logic first_hit;
      logic div_done;
      logic mean_zero;
      logic rsp_full;
   } dp_status_type;

endpackage

### sv/heartbeat_pulse_detector.sv
// Heartbeat pulse detector: takes one 10-bit pulse sensor sample per item and
// returns one result per sample (rate, beat flag, pulse level, last interval and
// threshold). A sample with no beat is captured, evaluated and passed to the
// result register. A beat also updates the guard by a reciprocal multiply;
// later beats also take the window mean by a reciprocal multiply and then
// run 60000 over the mean on the 16-bit serial divider, or set the rate to
// its maximum when the mean is zero. A new sample is taken while the previous
// result still waits on the output side. Configuration is written through the
// csr port while idle; the user must see to this, the block does not enforce it.
// Depends on hpd_pkg, hpd_ctrl, hpd_dp and hpd_div.

module heartbeat_pulse_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // req_tdata: sample[9:0], zero fill above
   input  logic [hpd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rsp_tdata: bpm[7:0], beat_found[8], pulse_high[9], interval_ms[21:10],
   // threshold[31:22]
   output logic [hpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hpd_pkg::CSR_DATA_W-1:0] csr_data
);
   import hpd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   hpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hpd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### sv/hpd_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on hpd_pkg for the operand width

module hpd_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [hpd_pkg::DIV_W-1:0] dividend,
   input  logic [hpd_pkg::DIV_W-1:0] divisor,
   output logic [hpd_pkg::DIV_W-1:0] quotient,
   output logic                     done
);
   import hpd_pkg::*;

   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   rem_shift;
   logic [DIV_W:0]   rem_diff;

   // trial subtraction of one step
   assign rem_shift = {rem_ff, dvd_ff[DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!rem_diff[DIV_W]) begin
            rem_in = rem_diff[DIV_W-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIV_W-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operands and partial remainder
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = dvd_ff;
   assign done     = done_ff;

endmodule

### sv/hpd_dp.sv
// datapath: configuration registers, beat tracking state, interval window,
// rate arithmetic and the result register; depends on hpd_pkg and hpd_div

module hpd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  hpd_pkg::dp_cmd_type           cmd,
   output hpd_pkg::dp_status_type        status,
   // req_tdata: sample
   input  logic [hpd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hpd_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rsp_tdata: bpm, beat_found, pulse_high, interval_ms, threshold
   output logic [hpd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hpd_pkg::*;

   // configuration
   logic [PERIOD_W-1:0]    period_ff;
   logic [SAMPLE_BITS-1:0] def_thr_ff;
   logic [REFR_W-1:0]      refr_ff;
   logic [TIMEOUT_W-1:0]   timeout_ff;

   // tracking state
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic [INTERVAL_W-1:0]  interval_ff, interval_in;
   logic [INTERVAL_W-1:0]  guard_ff;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [SAMPLE_BITS-1:0] trough_ff, trough_in;
   logic [SAMPLE_BITS-1:0] thr_ff, thr_in;
   logic                   pulse_ff, pulse_in;
   logic                   first_ff, first_in;
   logic                   second_ff, second_in;
   logic [INTERVAL_W-1:0]  window_ff [WINDOW_DEPTH];
   logic [INTERVAL_W-1:0]  window_in [WINDOW_DEPTH];
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [INTERVAL_W-1:0]  mean_ff;
   logic [BPM_W-1:0]       rate_ff;
   logic                   beat_ff;
   logic                   first_hit_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   // step arithmetic
   logic [ELAPSED_W:0]     n_sum;
   logic [ELAPSED_W-1:0]   n;
   logic                   s_lt, s_gt;
   logic                   past_guard;
   logic                   beat, first_hit, fall, tmo;
   logic [INTERVAL_W-1:0]  li_new;
   logic [SAMPLE_BITS-1:0] trough_upd;
   logic signed [SAMPLE_BITS:0] amp, half, mid;

   // constant divisions by reciprocal multiply
   logic [2*INTERVAL_W-1:0] guard_prod;
   logic [INTERVAL_W-1:0]   guard_q;
   logic [2*SUM_W-1:0]      mean_prod;
   logic [INTERVAL_W-1:0]   mean_q;

   // divider
   logic [DIV_W-1:0]       div_dvd, div_dvs, div_q;
   logic                   div_done;

   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         def_thr_ff <= THRESH_RESET;
         refr_ff    <= REFR_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD: period_ff  <= csr_data[PERIOD_W-1:0];
            CSR_DEFAULT_THR:   def_thr_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_REFRACTORY:    refr_ff    <= csr_data[REFR_W-1:0];
            CSR_TIMEOUT:       timeout_ff <= csr_data[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // elapsed time with saturation, crossings against the threshold
   assign n_sum = {1'b0, elapsed_ff} + (ELAPSED_W+1)'(period_ff);
   assign n     = n_sum[ELAPSED_W] ? ELAPSED_MAX : n_sum[ELAPSED_W-1:0];
   assign s_lt  = sample_ff < thr_ff;
   assign s_gt  = sample_ff > thr_ff;
   assign past_guard = n > ELAPSED_W'(guard_ff);
   assign beat  = (n > ELAPSED_W'(refr_ff)) && s_gt && !pulse_ff && past_guard;
   assign first_hit = beat && first_ff;
   assign fall  = s_lt && pulse_ff;
   assign tmo   = n > ELAPSED_W'(timeout_ff);
   assign li_new = (n > ELAPSED_W'(INTERVAL_MAX)) ? INTERVAL_MAX : n[INTERVAL_W-1:0];

   // trough as followed earlier in the same step
   assign trough_upd = (s_lt && past_guard && (sample_ff < trough_ff)) ? sample_ff
                                                                       : trough_ff;

   // new threshold halfway between trough and peak, truncated towards zero
   assign amp  = $signed({1'b0, peak_ff}) - $signed({1'b0, trough_upd});
   assign half = (amp + (SAMPLE_BITS+1)'(amp[SAMPLE_BITS])) >>> 1;
   assign mid  = half + $signed({1'b0, trough_upd});

   // next state of one step
   always_comb begin
      elapsed_in  = elapsed_ff;
      interval_in = interval_ff;
      peak_in     = peak_ff;
      trough_in   = trough_ff;
      thr_in      = thr_ff;
      pulse_in    = pulse_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      sum_in      = sum_ff;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         window_in[i] = window_ff[i];
      end
      if (cmd.eval) begin
         elapsed_in = n;
         if (s_lt && past_guard && (sample_ff < trough_ff)) begin
            trough_in = sample_ff;
         end
         if (s_gt && (sample_ff > peak_ff)) begin
            peak_in = sample_ff;
         end
         if (beat) begin
            pulse_in    = 1'b1;
            interval_in = li_new;
            elapsed_in  = '0;
            if (first_ff) begin
               first_in  = 1'b0;
               second_in = 1'b1;
            end else if (second_ff) begin
               // second beat seeds the whole window
               second_in = 1'b0;
               for (int i = 0; i < WINDOW_DEPTH; i++) begin
                  window_in[i] = li_new;
               end
               sum_in = SUM_W'(li_new) * SUM_W'(WINDOW_DEPTH);
            end else begin
               for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               window_in[WINDOW_DEPTH-1] = li_new;
               sum_in = sum_ff - SUM_W'(window_ff[0]) + SUM_W'(li_new);
            end
         end
         if (!first_hit) begin
            if (fall) begin
               pulse_in  = 1'b0;
               thr_in    = mid[SAMPLE_BITS-1:0];
               peak_in   = mid[SAMPLE_BITS-1:0];
               trough_in = mid[SAMPLE_BITS-1:0];
            end
            if (tmo) begin
               thr_in     = def_thr_ff;
               peak_in    = def_thr_ff;
               trough_in  = def_thr_ff;
               elapsed_in = '0;
               first_in   = 1'b1;
               second_in  = 1'b0;
            end
         end
      end
   end

   // interval over five and window sum over its depth
   assign guard_prod = interval_ff * (2*INTERVAL_W)'(GUARD_RECIP);
   assign guard_q    = INTERVAL_W'(guard_prod[2*INTERVAL_W-1:GUARD_SHIFT]);
   assign mean_prod  = sum_ff * (2*SUM_W)'(MEAN_RECIP);
   assign mean_q     = INTERVAL_W'(mean_prod[2*SUM_W-1:MEAN_SHIFT]);

   // tracking registers
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff  <= '0;
         interval_ff <= INTERVAL_RESET;
         guard_ff    <= GUARD_RESET;
         peak_ff     <= THRESH_RESET;
         trough_ff   <= THRESH_RESET;
         thr_ff      <= THRESH_RESET;
         pulse_ff    <= 1'b0;
         first_ff    <= 1'b1;
         second_ff   <= 1'b0;
         sum_ff      <= '0;
         rate_ff     <= '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         elapsed_ff  <= elapsed_in;
         interval_ff <= interval_in;
         peak_ff     <= peak_in;
         trough_ff   <= trough_in;
         thr_ff      <= thr_in;
         pulse_ff    <= pulse_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         sum_ff      <= sum_in;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= window_in[i];
         end
         if (cmd.store_guard) begin
            // three fifths: quotient by five, times three
            guard_ff <= guard_q + {guard_q[INTERVAL_W-2:0], 1'b0};
         end
         if (cmd.rate_sat) begin
            rate_ff <= BPM_MAX;
         end else if (cmd.store_rate) begin
            rate_ff <= (div_q > DIV_W'(BPM_MAX)) ? BPM_MAX : div_q[BPM_W-1:0];
         end
      end
   end

   // sample, step flags and window mean
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (cmd.eval) begin
         beat_ff      <= beat;
         first_hit_ff <= first_hit;
      end
      if (cmd.store_mean) begin
         mean_ff <= mean_q;
      end
   end

   // divider operands: one minute over the window mean
   assign div_dvd = DIV_W'(MINUTE_MS);
   assign div_dvs = DIV_W'(mean_ff);

   hpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_q),
      .done     (div_done)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= RSP_DATA_W'({thr_ff, interval_ff, pulse_ff,
                                     beat_ff && !first_hit_ff, rate_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.beat      = beat;
   assign status.first_hit = first_hit_ff;
   assign status.div_done  = div_done;
   assign status.mean_zero = (mean_ff == '0);
   assign status.rsp_full  = rsp_valid_ff;

   // a beat always restarts the elapsed count
   a_beat_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      cmd.eval && beat |=> elapsed_ff == '0)
      else $error("elapsed time not cleared after a beat");

   // a falling crossing pulls peak and trough onto the new threshold
   a_fall_levels: assert property (@(posedge clock) disable iff (reset)
      cmd.eval && fall && !tmo |=> peak_ff == thr_ff && trough_ff == thr_ff)
      else $error("levels differ from threshold after falling crossing");

   // a reported rate is never zero
   a_rate_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && beat_ff && !first_hit_ff |-> rate_ff != '0)
      else $error("beat reported with zero rate");

   // the result register is never overwritten while it still waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid_ff || rsp_tready)
      else $error("pending result overwritten");

endmodule

### sv/hpd_ctrl.sv
// controller: sequences one sample through evaluation, the rate arithmetic
// and the result register; depends on hpd_pkg

module hpd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   rsp_tready,
   input  hpd_pkg::dp_status_type status,
   output hpd_pkg::dp_cmd_type    cmd
);
   import hpd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_GUARD,
      S_MEAN,
      S_RATE_GO,
      S_RATE_WAIT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.beat ? S_GUARD : S_OUT;
         end
         S_GUARD: begin
            cmd.store_guard = 1'b1;
            state_in = status.first_hit ? S_OUT : S_MEAN;
         end
         S_MEAN: begin
            cmd.store_mean = 1'b1;
            state_in       = S_RATE_GO;
         end
         S_RATE_GO: begin
            if (status.mean_zero) begin
               cmd.rate_sat = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_RATE_WAIT;
            end
         end
         S_RATE_WAIT: begin
            if (status.div_done) begin
               cmd.store_rate = 1'b1;
               state_in       = S_OUT;
            end
         end
         S_OUT: begin
            if (!status.rsp_full || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule
